// ===== rtl/vara_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vara_pkg: shared widths, constants and types
// Widths of the fixed-point datapath that aligns two unit vectors, and the
// packet types passed between its pipeline sections.
// ----------------------------------------------------------------------------
package vara_pkg;

    // Q2.16 field and intermediate widths
    localparam int FIELD_W  = 18;
    localparam int PROD_W   = 36;   // Q2.16 x Q2.16, exact Q.32
    localparam int CROSS_W  = 37;   // difference of two products
    localparam int DOT_W    = 38;   // sum of three products
    localparam int W_W      = 21;   // rounded cross component, Q.16
    localparam int D_W      = 37;   // 1 + dot in Q.32
    localparam int AD_W     = 36;   // |d|
    localparam int WP_W     = 40;   // product of two cross components
    localparam int KK_W     = 41;   // one entry of K*K in Q.32
    localparam int AN_W     = 40;   // |K*K entry|
    localparam int NUM_W    = 57;   // dividend and shifted divisor
    localparam int Q_BITS   = 21;   // quotient bits below the clamp
    localparam int QM_W     = Q_BITS + 1;
    localparam int QS_W     = QM_W + 1;
    localparam int SUM_W    = QS_W + 1;
    localparam int N_LANES  = 6;    // distinct entries of symmetric K*K

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 168;

    // lanes of the divider, one per distinct K*K entry
    localparam int LANE_00 = 0;
    localparam int LANE_11 = 1;
    localparam int LANE_22 = 2;
    localparam int LANE_01 = 3;
    localparam int LANE_02 = 4;
    localparam int LANE_12 = 5;

    localparam logic signed [FIELD_W-1:0] ONE_Q16     = 18'sd65536;
    localparam logic signed [FIELD_W-1:0] NEG_ONE_Q16 = -18'sd65536;
    localparam logic signed [FIELD_W-1:0] SAT_MAX     = 18'sd131071;
    localparam logic signed [FIELD_W-1:0] SAT_MIN     = -18'sd131072;
    localparam logic signed [DOT_W-1:0]   ONE_Q32     = 38'sd4294967296;
    localparam logic signed [DOT_W-1:0]   NEG_ONE_Q32 = -38'sd4294967296;

    typedef logic signed [FIELD_W-1:0] fld_t;
    typedef logic signed [W_W-1:0]     w_t;

    // data that rides along the pipeline next to the division
    typedef struct packed {
        w_t   w0;
        w_t   w1;
        w_t   w2;
        logic opp;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic             neg;
        logic             ovf;
    } div_req_t;

    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [Q_BITS-1:0] q;
        logic              neg;
        logic              ovf;
    } div_lane_t;

    typedef struct packed {
        logic [QM_W-1:0] qmag;
        logic            neg;
    } div_res_t;

    typedef struct packed {
        fld_t r22;
        fld_t r21;
        fld_t r20;
        fld_t r12;
        fld_t r11;
        fld_t r10;
        fld_t r02;
        fld_t r01;
        fld_t r00;
        logic opp;
    } rot_t;

endpackage
`default_nettype wire

// ===== rtl/vara_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vara_front: cross and dot product
// Two stages: the nine component products, then the cross product rounded
// to Q.16, d = 1 + v.u in Q.32 and the opposite-vector detect.
// ----------------------------------------------------------------------------
module vara_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire vara_pkg::fld_t v_x,
    input  wire vara_pkg::fld_t v_y,
    input  wire vara_pkg::fld_t v_z,
    input  wire vara_pkg::fld_t u_x,
    input  wire vara_pkg::fld_t u_y,
    input  wire vara_pkg::fld_t u_z,
    output logic                out_valid,
    output vara_pkg::side_t     side_out,
    output logic signed [vara_pkg::D_W-1:0] d_out
);

    localparam int PW = vara_pkg::PROD_W;
    localparam int CW = vara_pkg::CROSS_W;
    localparam int DW = vara_pkg::DOT_W;

    // floor(x / 2^16 + 1/2)
    function automatic vara_pkg::w_t rnd_q16(input logic signed [CW-1:0] x);
        logic signed [CW-1:0] t;
        t = x + CW'(32'sd32768);
        t = t >>> 16;
        return t[vara_pkg::W_W-1:0];
    endfunction

    logic a_valid_reg;
    logic b_valid_reg;
    logic signed [PW-1:0] p_v1u2_reg, p_v2u1_reg, p_v2u0_reg;
    logic signed [PW-1:0] p_v0u2_reg, p_v0u1_reg, p_v1u0_reg;
    logic signed [PW-1:0] p_v0u0_reg, p_v1u1_reg, p_v2u2_reg;

    logic signed [CW-1:0] cross0, cross1, cross2;
    logic signed [DW-1:0] dot;
    logic signed [DW-1:0] d_full;
    vara_pkg::side_t      side_next;
    vara_pkg::side_t      side_reg;
    logic signed [vara_pkg::D_W-1:0] d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // stage A: products
    always_ff @(posedge aclk) begin
        if (en) begin
            p_v1u2_reg <= PW'(v_y) * PW'(u_z);
            p_v2u1_reg <= PW'(v_z) * PW'(u_y);
            p_v2u0_reg <= PW'(v_z) * PW'(u_x);
            p_v0u2_reg <= PW'(v_x) * PW'(u_z);
            p_v0u1_reg <= PW'(v_x) * PW'(u_y);
            p_v1u0_reg <= PW'(v_y) * PW'(u_x);
            p_v0u0_reg <= PW'(v_x) * PW'(u_x);
            p_v1u1_reg <= PW'(v_y) * PW'(u_y);
            p_v2u2_reg <= PW'(v_z) * PW'(u_z);
        end
    end

    // stage B: sums and rounding
    always_comb begin
        cross0 = CW'(p_v1u2_reg) - CW'(p_v2u1_reg);
        cross1 = CW'(p_v2u0_reg) - CW'(p_v0u2_reg);
        cross2 = CW'(p_v0u1_reg) - CW'(p_v1u0_reg);
        dot    = DW'(p_v0u0_reg) + DW'(p_v1u1_reg) + DW'(p_v2u2_reg);
        d_full = dot + vara_pkg::ONE_Q32;
        side_next.w0  = rnd_q16(cross0);
        side_next.w1  = rnd_q16(cross1);
        side_next.w2  = rnd_q16(cross2);
        side_next.opp = (dot == vara_pkg::NEG_ONE_Q32);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
            d_reg    <= d_full[vara_pkg::D_W-1:0];
        end
    end

    assign out_valid = b_valid_reg;
    assign side_out  = side_reg;
    assign d_out     = d_reg;

endmodule
`default_nettype wire

// ===== rtl/vara_kk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vara_kk: K*K entries and divider set-up
// Three stages: products of the cross components, signed K*K entries with
// magnitudes, then the rounding-biased dividend and the quotient clamp test.
// ----------------------------------------------------------------------------
module vara_kk (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire vara_pkg::side_t side_in,
    input  wire logic signed [vara_pkg::D_W-1:0] d_in,
    output logic                 out_valid,
    output vara_pkg::side_t      side_out,
    output logic [vara_pkg::AD_W-1:0] den_out,
    output vara_pkg::div_req_t [vara_pkg::N_LANES-1:0] req_out
);

    localparam int WPW = vara_pkg::WP_W;
    localparam int KKW = vara_pkg::KK_W;
    localparam int ANW = vara_pkg::AN_W;
    localparam int NW  = vara_pkg::NUM_W;
    localparam int ADW = vara_pkg::AD_W;
    localparam int NL  = vara_pkg::N_LANES;

    logic c_valid_reg, d_valid_reg, e_valid_reg;

    // stage C
    logic signed [WPW-1:0] sq0_reg, sq1_reg, sq2_reg, p01_reg, p02_reg, p12_reg;
    vara_pkg::side_t       side_c_reg;
    logic signed [vara_pkg::D_W-1:0] d_c_reg;

    // stage D
    logic signed [KKW-1:0] kk [NL];
    logic [ANW-1:0]        an_next [NL];
    logic [NL-1:0]         neg_next;
    logic signed [vara_pkg::D_W-1:0] ad_full;
    logic [ANW-1:0]        an_reg [NL];
    logic [NL-1:0]         neg_d_reg;
    logic [ADW-1:0]        ad_reg;
    vara_pkg::side_t       side_d_reg;

    // stage E
    vara_pkg::div_req_t [NL-1:0] req_next;
    vara_pkg::div_req_t [NL-1:0] req_reg;
    logic [ADW-1:0]        den_reg;
    vara_pkg::side_t       side_e_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= in_valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq0_reg    <= WPW'(side_in.w0) * WPW'(side_in.w0);
            sq1_reg    <= WPW'(side_in.w1) * WPW'(side_in.w1);
            sq2_reg    <= WPW'(side_in.w2) * WPW'(side_in.w2);
            p01_reg    <= WPW'(side_in.w0) * WPW'(side_in.w1);
            p02_reg    <= WPW'(side_in.w0) * WPW'(side_in.w2);
            p12_reg    <= WPW'(side_in.w1) * WPW'(side_in.w2);
            side_c_reg <= side_in;
            d_c_reg    <= d_in;
        end
    end

    // diagonal entries drop the own square from the norm
    always_comb begin
        kk[vara_pkg::LANE_00] = -(KKW'(sq1_reg) + KKW'(sq2_reg));
        kk[vara_pkg::LANE_11] = -(KKW'(sq0_reg) + KKW'(sq2_reg));
        kk[vara_pkg::LANE_22] = -(KKW'(sq0_reg) + KKW'(sq1_reg));
        kk[vara_pkg::LANE_01] = KKW'(p01_reg);
        kk[vara_pkg::LANE_02] = KKW'(p02_reg);
        kk[vara_pkg::LANE_12] = KKW'(p12_reg);
        for (int l = 0; l < NL; l++) begin
            an_next[l]  = kk[l][KKW-1] ? ANW'(-kk[l]) : ANW'(kk[l]);
            neg_next[l] = kk[l][KKW-1] ^ d_c_reg[vara_pkg::D_W-1];
        end
        ad_full = d_c_reg[vara_pkg::D_W-1] ? -d_c_reg : d_c_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < NL; l++) begin
                an_reg[l] <= an_next[l];
            end
            neg_d_reg  <= neg_next;
            ad_reg     <= ad_full[ADW-1:0];
            side_d_reg <= side_c_reg;
        end
    end

    // dividend carries half the divisor for round-half-away; clamp when the
    // quotient would reach 2^Q_BITS
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            req_next[l].num = NW'({an_reg[l], 16'h0000}) + NW'(ad_reg >> 1);
            req_next[l].neg = neg_d_reg[l];
            req_next[l].ovf = (req_next[l].num >= {ad_reg, vara_pkg::Q_BITS'(0)});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            req_reg    <= req_next;
            den_reg    <= ad_reg;
            side_e_reg <= side_d_reg;
        end
    end

    assign out_valid = e_valid_reg;
    assign side_out  = side_e_reg;
    assign den_out   = den_reg;
    assign req_out   = req_reg;

endmodule
`default_nettype wire

// ===== rtl/vara_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vara_div: pipelined restoring divider, six lanes
// One quotient bit per stage, most significant first, sharing one divisor
// across the lanes. Clamped results report 2^Q_BITS.
// ----------------------------------------------------------------------------
module vara_div (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire vara_pkg::side_t side_in,
    input  wire logic [vara_pkg::AD_W-1:0] den_in,
    input  wire vara_pkg::div_req_t [vara_pkg::N_LANES-1:0] req_in,
    output logic                 out_valid,
    output vara_pkg::side_t      side_out,
    output vara_pkg::div_res_t [vara_pkg::N_LANES-1:0] res_out
);

    localparam int NS  = vara_pkg::Q_BITS;
    localparam int NL  = vara_pkg::N_LANES;
    localparam int NW  = vara_pkg::NUM_W;
    localparam int ADW = vara_pkg::AD_W;

    vara_pkg::div_lane_t [NL-1:0] lane_in   [NS];
    vara_pkg::div_lane_t [NL-1:0] lane_next [NS];
    vara_pkg::div_lane_t [NL-1:0] lane_reg  [NS];
    logic [ADW-1:0]               den_in_s  [NS];
    logic [ADW-1:0]               den_reg   [NS];
    vara_pkg::side_t              side_in_s [NS];
    vara_pkg::side_t              side_reg  [NS];
    logic [NS-1:0]                vld_in;
    logic [NS-1:0]                vld_reg;

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int K = NS - 1 - j;

        if (j == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < NL; l++) begin
                    lane_in[j][l].rem = req_in[l].num;
                    lane_in[j][l].q   = '0;
                    lane_in[j][l].neg = req_in[l].neg;
                    lane_in[j][l].ovf = req_in[l].ovf;
                end
                den_in_s[j]  = den_in;
                side_in_s[j] = side_in;
                vld_in[j]    = in_valid;
            end
        end else begin : g_rest
            always_comb begin
                lane_in[j]   = lane_reg[j-1];
                den_in_s[j]  = den_reg[j-1];
                side_in_s[j] = side_reg[j-1];
                vld_in[j]    = vld_reg[j-1];
            end
        end

        // trial subtract of the divisor at this bit weight
        always_comb begin
            logic [NW-1:0] shifted;
            shifted = NW'(den_in_s[j]) << K;
            for (int l = 0; l < NL; l++) begin
                lane_next[j][l] = lane_in[j][l];
                if (lane_in[j][l].rem >= shifted) begin
                    lane_next[j][l].rem = lane_in[j][l].rem - shifted;
                    lane_next[j][l].q   = {lane_in[j][l].q[NS-2:0], 1'b1};
                end else begin
                    lane_next[j][l].q   = {lane_in[j][l].q[NS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_in[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                lane_reg[j] <= lane_next[j];
                den_reg[j]  <= den_in_s[j];
                side_reg[j] <= side_in_s[j];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            res_out[l].qmag = lane_reg[NS-1][l].ovf ? {1'b1, NS'(0)}
                                                    : {1'b0, lane_reg[NS-1][l].q};
            res_out[l].neg  = lane_reg[NS-1][l].neg;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule
`default_nettype wire

// ===== rtl/vara_out.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vara_out: matrix assembly and saturation
// Two stages: sign the quotients, then add identity and skew terms, saturate
// to Q2.16 and substitute the fixed half-turn for opposite vectors.
// ----------------------------------------------------------------------------
module vara_out (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire vara_pkg::side_t side_in,
    input  wire vara_pkg::div_res_t [vara_pkg::N_LANES-1:0] res_in,
    output logic                 out_valid,
    output vara_pkg::rot_t       rot_out
);

    localparam int NL  = vara_pkg::N_LANES;
    localparam int QSW = vara_pkg::QS_W;
    localparam int SW  = vara_pkg::SUM_W;
    localparam int FW  = vara_pkg::FIELD_W;

    function automatic vara_pkg::fld_t entry(input logic diag,
                                             input logic signed [SW-1:0] kterm,
                                             input logic signed [QSW-1:0] q);
        logic signed [SW-1:0] ione;
        logic signed [SW-1:0] s;
        ione = diag ? SW'(vara_pkg::ONE_Q16) : SW'(0);
        s    = ione + kterm + SW'(q);
        if (s > SW'(vara_pkg::SAT_MAX)) begin
            return vara_pkg::SAT_MAX;
        end else if (s < SW'(vara_pkg::SAT_MIN)) begin
            return vara_pkg::SAT_MIN;
        end
        return s[FW-1:0];
    endfunction

    logic f_valid_reg, g_valid_reg;
    logic signed [QSW-1:0] qs_next [NL];
    logic signed [QSW-1:0] qs_reg  [NL];
    vara_pkg::side_t       side_f_reg;
    logic signed [SW-1:0]  kw0, kw1, kw2;
    vara_pkg::rot_t        rot_next;
    vara_pkg::rot_t        rot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= in_valid;
            g_valid_reg <= f_valid_reg;
        end
    end

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            qs_next[l] = res_in[l].neg ? -$signed({1'b0, res_in[l].qmag})
                                       : $signed({1'b0, res_in[l].qmag});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < NL; l++) begin
                qs_reg[l] <= qs_next[l];
            end
            side_f_reg <= side_in;
        end
    end

    always_comb begin
        kw0 = SW'(side_f_reg.w0);
        kw1 = SW'(side_f_reg.w1);
        kw2 = SW'(side_f_reg.w2);
        if (side_f_reg.opp) begin
            rot_next     = '0;
            rot_next.r00 = vara_pkg::ONE_Q16;
            rot_next.r11 = vara_pkg::NEG_ONE_Q16;
            rot_next.r22 = vara_pkg::NEG_ONE_Q16;
            rot_next.opp = 1'b1;
        end else begin
            rot_next.r00 = entry(1'b1, SW'(0), qs_reg[vara_pkg::LANE_00]);
            rot_next.r01 = entry(1'b0, -kw2,   qs_reg[vara_pkg::LANE_01]);
            rot_next.r02 = entry(1'b0, kw1,    qs_reg[vara_pkg::LANE_02]);
            rot_next.r10 = entry(1'b0, kw2,    qs_reg[vara_pkg::LANE_01]);
            rot_next.r11 = entry(1'b1, SW'(0), qs_reg[vara_pkg::LANE_11]);
            rot_next.r12 = entry(1'b0, -kw0,   qs_reg[vara_pkg::LANE_12]);
            rot_next.r20 = entry(1'b0, -kw1,   qs_reg[vara_pkg::LANE_02]);
            rot_next.r21 = entry(1'b0, kw0,    qs_reg[vara_pkg::LANE_12]);
            rot_next.r22 = entry(1'b1, SW'(0), qs_reg[vara_pkg::LANE_22]);
            rot_next.opp = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rot_reg <= rot_next;
        end
    end

    assign out_valid = g_valid_reg;
    assign rot_out   = rot_reg;

endmodule
`default_nettype wire

// ===== rtl/vector_align_rotation_matrix_top.sv =====
`default_nettype none
// Pipeline: a request accepted on s_tdata passes 28 pipeline stages and then the
// output register before it shows on m_tvalid.
// Throughput: one request per cycle while the skid slot is free; the 21-stage
// restoring divider, one quotient bit per stage, sets the depth.
// Reset: aresetn is synchronous, active low; it clears every valid bit and the
// skid buffer. Data registers are not reset.
// ----------------------------------------------------------------------------
// vector_align_rotation_matrix_top: rotation taking one unit vector to another
// Computes R = I + K + K*K / (1 + v.u) from two Q2.16 unit vectors, with a
// fixed half-turn about x when the vectors are exactly opposite.
// ----------------------------------------------------------------------------
module vector_align_rotation_matrix_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata, from bit 0 up: v_x, v_y, v_z, u_x, u_y, u_z (18 bits each), 4 zero bits
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [vara_pkg::IN_TDATA_W-1:0] s_tdata,
    // m_tdata, from bit 0 up: r00, r01, r02, r10, r11, r12, r20, r21, r22
    // (18 bits each), 6 zero bits
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [vara_pkg::OUT_TDATA_W-1:0] m_tdata,
    // m_tuser, bit 0: opposite_flag
    output logic [0:0]       m_tuser
);

    localparam int FW = vara_pkg::FIELD_W;
    localparam int NL = vara_pkg::N_LANES;

    // Global advance: the whole pipeline moves whenever the skid slot is
    // free, so one request can still enter while a result waits on m_tready.
    logic en;

    vara_pkg::fld_t in_vx, in_vy, in_vz, in_ux, in_uy, in_uz;

    logic                              fr_valid;
    vara_pkg::side_t                   fr_side;
    logic signed [vara_pkg::D_W-1:0]   fr_d;

    logic                              kk_valid;
    vara_pkg::side_t                   kk_side;
    logic [vara_pkg::AD_W-1:0]         kk_den;
    vara_pkg::div_req_t [NL-1:0]       kk_req;

    logic                              dv_valid;
    vara_pkg::side_t                   dv_side;
    vara_pkg::div_res_t [NL-1:0]       dv_res;

    logic                              pipe_valid;
    vara_pkg::rot_t                    pipe_rot;

    logic                              m_valid_reg;
    vara_pkg::rot_t                    out_reg;
    logic                              skid_valid_reg;
    vara_pkg::rot_t                    skid_reg;
    logic                              out_take;

    // unpack the request, v_x in the lowest bits
    assign in_vx = s_tdata[1*FW-1:0*FW];
    assign in_vy = s_tdata[2*FW-1:1*FW];
    assign in_vz = s_tdata[3*FW-1:2*FW];
    assign in_ux = s_tdata[4*FW-1:3*FW];
    assign in_uy = s_tdata[5*FW-1:4*FW];
    assign in_uz = s_tdata[6*FW-1:5*FW];

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // cross product, dot product, opposite detect
    vara_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .v_x       (in_vx),
        .v_y       (in_vy),
        .v_z       (in_vz),
        .u_x       (in_ux),
        .u_y       (in_uy),
        .u_z       (in_uz),
        .out_valid (fr_valid),
        .side_out  (fr_side),
        .d_out     (fr_d)
    );

    // K*K entries, magnitudes, dividend set-up
    vara_kk u_kk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .side_in   (fr_side),
        .d_in      (fr_d),
        .out_valid (kk_valid),
        .side_out  (kk_side),
        .den_out   (kk_den),
        .req_out   (kk_req)
    );

    // divide the six distinct entries by 1 + c
    vara_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (kk_valid),
        .side_in   (kk_side),
        .den_in    (kk_den),
        .req_in    (kk_req),
        .out_valid (dv_valid),
        .side_out  (dv_side),
        .res_out   (dv_res)
    );

    // add I and K, saturate, apply the opposite case
    vara_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv_valid),
        .side_in   (dv_side),
        .res_in    (dv_res),
        .out_valid (pipe_valid),
        .rot_out   (pipe_rot)
    );

    // Output register with one skid slot. While the skid slot holds a
    // result the pipeline stalls; drain it first when the sink is ready.
    assign out_take = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (out_take) begin
            m_valid_reg <= pipe_valid;
        end else if (pipe_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg <= skid_reg;
            end
        end else if (out_take) begin
            out_reg <= pipe_rot;
        end else begin
            skid_reg <= pipe_rot;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b000000,
                       out_reg.r22, out_reg.r21, out_reg.r20,
                       out_reg.r12, out_reg.r11, out_reg.r10,
                       out_reg.r02, out_reg.r01, out_reg.r00};
    assign m_tuser  = out_reg.opp;

endmodule
`default_nettype wire

// ===== rtl/vara_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vara_checker: port-level assertions
// Watches the stream ports of the top level for stall, reset and
// opposite-vector behavior.
// ----------------------------------------------------------------------------
module vara_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [vara_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic [0:0] m_tuser
);

    localparam int FW = vara_pkg::FIELD_W;

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // the opposite flag always comes with the fixed half-turn about x
    a_opp_matrix: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[1*FW-1:0*FW] == vara_pkg::ONE_Q16 &&
            m_tdata[2*FW-1:1*FW] == '0 &&
            m_tdata[3*FW-1:2*FW] == '0 &&
            m_tdata[4*FW-1:3*FW] == '0 &&
            m_tdata[5*FW-1:4*FW] == vara_pkg::NEG_ONE_Q16 &&
            m_tdata[6*FW-1:5*FW] == '0 &&
            m_tdata[7*FW-1:6*FW] == '0 &&
            m_tdata[8*FW-1:7*FW] == '0 &&
            m_tdata[9*FW-1:8*FW] == vara_pkg::NEG_ONE_Q16)
        else $error("opposite flag without fixed matrix");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // input backpressure only follows a stalled output
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // a drained output frees the input in the next cycle
    a_ready_back: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && m_tready |=> s_tready)
        else $error("input still stalled after output drained");

endmodule

bind vector_align_rotation_matrix_top vara_checker u_vara_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
